/* rtl/core/dssf_pkg.sv */
// ----------------------------------------------------------------------------
// dssf_pkg
// shared types and constants of the dual stepper setpoint follower
// ----------------------------------------------------------------------------
`default_nettype none

package dssf_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  // event kinds
  localparam logic [ModeW-1:0] MODE_POT   = 2'd0;
  localparam logic [ModeW-1:0] MODE_TICK  = 2'd1;
  localparam logic [ModeW-1:0] MODE_LIMIT = 2'd2;
  localparam logic [ModeW-1:0] MODE_CLOCK = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLITCH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd2;

  localparam logic [CfgW-1:0] DEADBAND_RST = 16'd5000;
  localparam logic [CfgW-1:0] GLITCH_RST   = 16'd5000;
  localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd1000;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PosW-1:0]  pot_sample;
    logic             limit_one_level;
    logic             limit_two_level;
  } event_t;

  typedef struct packed {
    logic [CfgW-1:0] deadband;
    logic [CfgW-1:0] glitch_limit;
    logic [CfgW-1:0] debounce_count;
  } cfg_t;

  // per-axis control from the shared update logic
  typedef struct packed {
    logic            fire;
    logic [ModeW-1:0] mode;
    logic            level;
    logic [PosW-1:0] setpoint;
    logic            clock_level;
  } axis_ctrl_t;

  // next-state view of one axis
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            enable;
    logic            forward;
    logic            step;
  } axis_stat_t;

endpackage

`default_nettype wire

/* rtl/core/dssf_in_stage.sv */
// ----------------------------------------------------------------------------
// dssf_in_stage
// input register: captures one event beat and holds it until it is consumed
// ----------------------------------------------------------------------------
`default_nettype none

module dssf_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dssf_pkg::event_t in_event,
  input  wire logic            take,
  output logic                 evt_valid,
  output dssf_pkg::event_t     evt
);
  import dssf_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  event_t evt_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt_r <= in_event;
    end
  end

  assign evt_valid = valid_r;
  assign evt       = evt_r;

endmodule

`default_nettype wire

/* rtl/core/dssf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dssf_cfg_regs
// configuration registers: deadband, glitch limit, debounce count
// ----------------------------------------------------------------------------
`default_nettype none

module dssf_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [dssf_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dssf_pkg::CfgW-1:0]    cfg_wdata,
  output dssf_pkg::cfg_t                    cfg
);
  import dssf_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband       <= DEADBAND_RST;
      cfg_r.glitch_limit   <= GLITCH_RST;
      cfg_r.debounce_count <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEADBAND: cfg_r.deadband       <= cfg_wdata;
        CFG_GLITCH:   cfg_r.glitch_limit   <= cfg_wdata;
        CFG_DEBOUNCE: cfg_r.debounce_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/dssf_axis.sv */
// ----------------------------------------------------------------------------
// dssf_axis
// state of one stepper axis: tick stepping, limit debounce, step pin
// ----------------------------------------------------------------------------
`default_nettype none

module dssf_axis (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dssf_pkg::axis_ctrl_t ctrl,
  input  wire dssf_pkg::cfg_t       cfg,
  output dssf_pkg::axis_stat_t      stat
);
  import dssf_pkg::*;

  logic [PosW-1:0] setpoint_r, setpoint_nxt;
  logic [PosW-1:0] position_r, position_nxt;
  logic            forward_r, forward_nxt;
  logic            enable_r, enable_nxt;
  logic            step_r, step_nxt;
  logic [CfgW-1:0] run_r, run_nxt;
  logic            was_high_r, was_high_nxt;

  logic [PosW-1:0] err_fwd;
  logic [PosW-1:0] err_back;
  logic            in_band;
  logic [CfgW-1:0] run_inc;

  assign err_fwd  = position_r - setpoint_r;
  assign err_back = setpoint_r - position_r;
  assign in_band  = (err_fwd <= cfg.deadband) || (err_back <= cfg.deadband);
  assign run_inc  = was_high_r ? run_r + 1'b1 : run_r;

  always_comb begin
    setpoint_nxt = setpoint_r;
    position_nxt = position_r;
    forward_nxt  = forward_r;
    enable_nxt   = enable_r;
    step_nxt     = step_r;
    run_nxt      = run_r;
    was_high_nxt = was_high_r;
    case (ctrl.mode)
      MODE_POT: begin
        setpoint_nxt = ctrl.setpoint;
      end
      MODE_TICK: begin
        if (in_band) begin
          setpoint_nxt = position_r;
          enable_nxt   = 1'b0;
          step_nxt     = 1'b0;
        end else begin
          enable_nxt = 1'b1;
          if (setpoint_r > position_r) begin
            forward_nxt  = 1'b1;
            position_nxt = position_r + 1'b1;
          end else begin
            forward_nxt  = 1'b0;
            position_nxt = position_r - 1'b1;
          end
        end
      end
      MODE_LIMIT: begin
        run_nxt      = ctrl.level ? run_inc : '0;
        was_high_nxt = ctrl.level;
        if (ctrl.level && (run_inc > cfg.debounce_count)) begin
          setpoint_nxt = position_r;
          enable_nxt   = 1'b0;
          step_nxt     = 1'b0;
          run_nxt      = '0;
        end
      end
      MODE_CLOCK: begin
        step_nxt = ctrl.clock_level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      position_r <= '0;
      forward_r  <= 1'b0;
      enable_r   <= 1'b1;
      step_r     <= 1'b0;
      run_r      <= '0;
      was_high_r <= 1'b0;
    end else if (ctrl.fire) begin
      setpoint_r <= setpoint_nxt;
      position_r <= position_nxt;
      forward_r  <= forward_nxt;
      enable_r   <= enable_nxt;
      step_r     <= step_nxt;
      run_r      <= run_nxt;
      was_high_r <= was_high_nxt;
    end
  end

  assign stat.position = position_nxt;
  assign stat.enable   = enable_nxt;
  assign stat.forward  = forward_nxt;
  assign stat.step     = step_nxt;

endmodule

`default_nettype wire

/* rtl/core/dssf_out_stage.sv */
// ----------------------------------------------------------------------------
// dssf_out_stage
// result register: holds one result beat until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module dssf_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [dssf_pkg::OutDataW-1:0] load_data,
  output logic                               can_load,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dssf_pkg::OutDataW-1:0]      out_data
);
  import dssf_pkg::*;

  logic                valid_r;
  logic                valid_nxt;
  logic [OutDataW-1:0] data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/core/dual_stepper_setpoint_follower_core.sv */
// ----------------------------------------------------------------------------
// dual_stepper_setpoint_follower_core
// two stepper axes following one filtered potentiometer setpoint
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  in_*     | in  | tuser: mode[1:0]; tdata: pot_sample, limit_one, limit_two
//  out_*    | out | tdata: filtered, pos one, pos two, enables, forwards, steps
//  cfg_*    | in  | index 0 deadband, 1 glitch limit, 2 debounce count
//
// one event per cycle while out_tready holds; out_tvalid rises after the in_ beat passes the
// input register, then the state update into the result register
// synchronous active-low reset clears filter, clock level and axis state and both stage valids
// a stalled result holds the pipe; one more event waits in the input register
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stepper_setpoint_follower_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] pot_sample, [16] limit_one_level, [17] limit_two_level
  input  wire logic [dssf_pkg::InDataW-1:0]  in_tdata,
  // [1:0] mode
  input  wire logic [dssf_pkg::ModeW-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [15:0] filtered_value, [31:16] axis_one_position, [47:32] axis_two_position,
  // [48] axis_one_enable, [49] axis_two_enable, [50] axis_one_forward,
  // [51] axis_two_forward, [52] axis_one_step, [53] axis_two_step
  output logic [dssf_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [dssf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [dssf_pkg::CfgW-1:0]     cfg_wdata
);
  import dssf_pkg::*;

  event_t             in_event;
  event_t             evt;
  logic               evt_valid;
  logic               can_load;
  logic               fire;
  cfg_t               cfg;
  axis_ctrl_t         ctrl_one, ctrl_two;
  axis_stat_t         stat_one, stat_two;
  logic [OutDataW-1:0] result;

  logic [PosW-1:0]    filt_r, filt_nxt;
  logic               clk_level_r, clk_level_nxt;
  logic [PosW-1:0]    diff;
  logic [PosW+1:0]    blend;

  assign in_event.mode            = in_tuser;
  assign in_event.pot_sample      = in_tdata[PosW-1:0];
  assign in_event.limit_one_level = in_tdata[PosW];
  assign in_event.limit_two_level = in_tdata[PosW+1];

  dssf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_event (in_event),
    .take     (fire),
    .evt_valid(evt_valid),
    .evt      (evt)
  );

  dssf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  assign fire = evt_valid && can_load;

  // pot filter
  assign diff  = (evt.pot_sample > filt_r) ? evt.pot_sample - filt_r
                                           : filt_r - evt.pot_sample;
  assign blend = {2'b00, evt.pot_sample} + {2'b00, filt_r} + {1'b0, filt_r, 1'b0};

  always_comb begin
    filt_nxt      = filt_r;
    clk_level_nxt = clk_level_r;
    if (evt.mode == MODE_POT && diff <= cfg.glitch_limit) begin
      filt_nxt = blend[PosW+1:2];
    end
    if (evt.mode == MODE_CLOCK) begin
      clk_level_nxt = !clk_level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r      <= '0;
      clk_level_r <= 1'b0;
    end else if (fire) begin
      filt_r      <= filt_nxt;
      clk_level_r <= clk_level_nxt;
    end
  end

  assign ctrl_one.fire        = fire;
  assign ctrl_one.mode        = evt.mode;
  assign ctrl_one.level       = evt.limit_one_level;
  assign ctrl_one.setpoint    = filt_nxt;
  assign ctrl_one.clock_level = clk_level_nxt;

  assign ctrl_two.fire        = fire;
  assign ctrl_two.mode        = evt.mode;
  assign ctrl_two.level       = evt.limit_two_level;
  assign ctrl_two.setpoint    = filt_nxt;
  assign ctrl_two.clock_level = clk_level_nxt;

  dssf_axis u_axis_one (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl_one),
    .cfg  (cfg),
    .stat (stat_one)
  );

  dssf_axis u_axis_two (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl_two),
    .cfg  (cfg),
    .stat (stat_two)
  );

  assign result = {2'b00,
                   stat_two.step, stat_one.step,
                   stat_two.forward, stat_one.forward,
                   stat_two.enable, stat_one.enable,
                   stat_two.position, stat_one.position,
                   filt_nxt};

  dssf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .load_data(result),
    .can_load (can_load),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire
